// ===== rtl/tssc_pkg.sv =====
// tssc_pkg: shared types, constants and helper functions for the timed
// sensor sample collector and its checker
// no dependencies
`default_nettype none

package tssc_pkg;

  // ring buffer geometry
  localparam int BUFFER_DEPTH = 32;
  localparam int ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

  // field widths
  localparam int TIME_W  = 32;
  localparam int VAL_W   = 18;
  localparam int KIND_W  = 2;
  localparam int ADC_W   = 12;
  localparam int MV_W    = 12;
  localparam int PCT_W   = 7;
  localparam int CFG_W   = 22;
  localparam int CIDX_W  = 2;
  localparam int PP_W    = 10;
  localparam int GP_W    = 14;
  localparam int BP_W    = 22;

  // converter scaling: mv = count * 3300 / 4096
  localparam int ADC_FULL_MV = 3300;
  localparam int ADC_SHIFT   = 12;

  // battery percent window
  localparam int BATT_EMPTY_MV = 2500;
  localparam int BATT_FULL_MV  = 4200;
  localparam int PCT_FULL      = 100;
  // (mv - 2500) * 100 / 1700 == (mv - 2500) / 17, done as a reciprocal
  localparam int PCT_SHIFT     = 16;
  localparam int PCT_RECIP     = ((1 << PCT_SHIFT) + 16) / 17;

  // register reset values
  localparam int PULSE_PERIOD_RST   = 10;
  localparam int GAS_PERIOD_RST     = 100;
  localparam int BATTERY_PERIOD_RST = 60000;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_POP    = 2'd1,
    OP_NEWEST = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_PULSE_PERIOD   = 2'd0,
    REG_GAS_PERIOD     = 2'd1,
    REG_BATTERY_PERIOD = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_t;

  localparam logic [KIND_W-1:0] KIND_PULSE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GAS     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BATTERY = 2'd2;
  // never stored, so a query for it matches nothing
  localparam logic [KIND_W-1:0] KIND_NONE    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_PULSE,
    S_UPD_GAS,
    S_BATT_MV,
    S_BATT_PCT,
    S_UPD_BATT,
    S_POP,
    S_POP_DATA,
    S_SRCH,
    S_FINISH
  } state_t;

  // one ring buffer entry
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  second;
    logic [VAL_W-1:0]  first;
  } entry_t;

  function automatic addr_t next_slot(input addr_t i);
    return (i == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic addr_t prev_slot(input addr_t i);
    return (i == '0) ? ADDR_W'(BUFFER_DEPTH - 1) : i - 1'b1;
  endfunction

  function automatic logic [MV_W-1:0] adc_to_mv(input logic [ADC_W-1:0] count);
    logic [ADC_W+ADC_SHIFT-1:0] prod;
    prod = ADC_W'(count) * (ADC_W + ADC_SHIFT)'(ADC_FULL_MV);
    return prod[ADC_SHIFT +: MV_W];
  endfunction

  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] last,
                                   input logic [TIME_W-1:0] period);
    logic [TIME_W-1:0] diff;
    diff = now - last;
    return diff >= period;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/timed_sensor_sample_collector.sv =====
// timed_sensor_sample_collector: periodic sampling of pulse, gas and battery
// readings into a timestamped ring buffer, with pop and newest-of-kind query
// depends on tssc_pkg
`default_nettype none

// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------
// request   | start / busy            | operation, now_ms, readings, wanted_kind
// result    | done (one-cycle strobe) | found ... battery_charge
// config    | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an update walks pulse, gas, battery scaling (multiply in S_BATT_MV, then
// reciprocal multiply in S_BATT_PCT) and the battery push before done. a pop
// reads the oldest entry through the registered read of the buffer memory and
// skips the data step when the buffer is empty. a newest-of-kind query makes
// one memory read per entry walked back from the newest. request 3 just ends.
// rst is synchronous, clears the indices, totals and timers and resets periods.
// the result cannot be stalled; a new request is taken in the cycle done shows

module timed_sensor_sample_collector
  import tssc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // request
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           operation,
  input  wire logic [TIME_W-1:0]    now_ms,
  input  wire logic                 pulse_ready,
  input  wire logic [VAL_W-1:0]     pulse_red,
  input  wire logic [VAL_W-1:0]     pulse_infrared,
  input  wire logic [ADC_W-1:0]     gas_adc,
  input  wire logic                 heater_active,
  input  wire logic [ADC_W-1:0]     battery_adc,
  input  wire logic [KIND_W-1:0]    wanted_kind,
  // result
  output logic                      done,
  output logic                      found,
  output logic [TIME_W-1:0]         sample_time,
  output logic [KIND_W-1:0]         sample_kind,
  output logic [VAL_W-1:0]          first_value,
  output logic [VAL_W-1:0]          second_value,
  output logic [CNT_W-1:0]          occupancy,
  output logic [2:0]                pushed_mask,
  output logic [TIME_W-1:0]         pulse_samples,
  output logic [TIME_W-1:0]         gas_samples,
  output logic [TIME_W-1:0]         update_count,
  output logic [MV_W-1:0]           battery_millivolts,
  output logic [PCT_W-1:0]          battery_charge,
  // configuration
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CIDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  state_t state, state_next;

  // period registers
  logic [PP_W-1:0] pulse_period;
  logic [GP_W-1:0] gas_period;
  logic [BP_W-1:0] battery_period;

  // ring buffer control
  addr_t wr_idx, rd_idx;
  cnt_t  held;

  // sampling timers and totals
  logic [TIME_W-1:0] last_pulse, last_gas, last_battery;
  logic [TIME_W-1:0] pulse_total, gas_total, updates_total;
  logic [MV_W-1:0]   batt_mv_held;
  logic [PCT_W-1:0]  batt_pct_held;

  // latched request
  op_t               op_r;
  logic [TIME_W-1:0] now_r;
  logic              pready_r;
  logic [VAL_W-1:0]  red_r, ir_r;
  logic [ADC_W-1:0]  gas_adc_r, batt_adc_r;
  logic              heater_r;
  logic [KIND_W-1:0] want_r;

  // working registers
  logic [MV_W-1:0]   bmv_calc;
  logic [PCT_W-1:0]  bpct_calc;
  logic [2:0]        mask;
  logic              res_found;
  entry_t            res_entry;

  // backwards search
  addr_t scan_slot;
  cnt_t  scan_left;
  logic  chk_valid;

  // buffer memory, registered read
  entry_t mem [BUFFER_DEPTH];
  entry_t rd_q;
  addr_t  rd_addr;
  logic   push_en;
  entry_t push_data;

  // combinational helpers
  logic              issue, match;
  logic [MV_W-1:0]   gas_mv;
  logic [MV_W-1:0]   bdiff;
  logic [MV_W+PCT_SHIFT-1:0] pct_prod;
  logic [PCT_W-1:0]  pct_val;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign gas_mv   = adc_to_mv(gas_adc_r);
  assign bdiff    = bmv_calc - MV_W'(BATT_EMPTY_MV);
  assign pct_prod = (MV_W + PCT_SHIFT)'(bdiff) * (MV_W + PCT_SHIFT)'(PCT_RECIP);

  always_comb begin
    if (bmv_calc <= MV_W'(BATT_EMPTY_MV)) begin
      pct_val = '0;
    end else if ({1'b0, bmv_calc} >= (MV_W + 1)'(BATT_FULL_MV)) begin
      pct_val = PCT_W'(PCT_FULL);
    end else begin
      pct_val = pct_prod[PCT_SHIFT +: PCT_W];
    end
  end

  assign issue = (scan_left != '0);
  assign match = chk_valid && (rd_q.kind == want_r);

  // next state, push request and read address
  always_comb begin
    state_next = state;
    push_en    = 1'b0;
    push_data  = '{stamp: now_r, kind: KIND_PULSE, second: ir_r, first: red_r};
    rd_addr    = rd_idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (op_t'(operation))
            OP_UPDATE: state_next = S_UPD_PULSE;
            OP_POP:    state_next = S_POP;
            OP_NEWEST: state_next = S_SRCH;
            OP_NONE:   state_next = S_FINISH;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_UPD_PULSE: begin
        push_en    = pready_r && elapsed(now_r, last_pulse, TIME_W'(pulse_period));
        state_next = S_UPD_GAS;
      end
      S_UPD_GAS: begin
        push_en    = elapsed(now_r, last_gas, TIME_W'(gas_period));
        push_data  = '{stamp: now_r, kind: KIND_GAS, second: VAL_W'(heater_r),
                       first: VAL_W'(gas_mv)};
        state_next = S_BATT_MV;
      end
      S_BATT_MV:  state_next = S_BATT_PCT;
      S_BATT_PCT: state_next = S_UPD_BATT;
      S_UPD_BATT: begin
        push_en    = elapsed(now_r, last_battery, TIME_W'(battery_period));
        push_data  = '{stamp: now_r, kind: KIND_BATTERY, second: VAL_W'(bpct_calc),
                       first: VAL_W'(bmv_calc)};
        state_next = S_FINISH;
      end
      S_POP: begin
        state_next = (held == '0) ? S_FINISH : S_POP_DATA;
      end
      S_POP_DATA: state_next = S_FINISH;
      S_SRCH: begin
        rd_addr = scan_slot;
        if (match || (!issue && !chk_valid)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory: write on push, read every cycle
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_idx] <= push_data;
    end
    rd_q <= mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      pulse_period   <= PP_W'(PULSE_PERIOD_RST);
      gas_period     <= GP_W'(GAS_PERIOD_RST);
      battery_period <= BP_W'(BATTERY_PERIOD_RST);
      wr_idx         <= '0;
      rd_idx         <= '0;
      held           <= '0;
      last_pulse     <= '0;
      last_gas       <= '0;
      last_battery   <= '0;
      pulse_total    <= '0;
      gas_total      <= '0;
      updates_total  <= '0;
      batt_mv_held   <= '0;
      batt_pct_held  <= '0;
      chk_valid      <= 1'b0;
      done           <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_FINISH);

      // register writes, taken in any state
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PULSE_PERIOD:   pulse_period   <= cfg_data[PP_W-1:0];
          REG_GAS_PERIOD:     gas_period     <= cfg_data[GP_W-1:0];
          REG_BATTERY_PERIOD: battery_period <= cfg_data[BP_W-1:0];
          REG_UNUSED:         ;
          default:            ;
        endcase
      end

      // push, dropping the oldest entry when full
      if (push_en) begin
        wr_idx <= next_slot(wr_idx);
        if (held == CNT_W'(BUFFER_DEPTH)) begin
          rd_idx <= next_slot(rd_idx);
        end else begin
          held <= held + 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          chk_valid <= 1'b0;
        end
        S_UPD_PULSE: begin
          if (push_en) begin
            pulse_total <= pulse_total + 1'b1;
            last_pulse  <= now_r;
          end
        end
        S_UPD_GAS: begin
          if (push_en) begin
            gas_total <= gas_total + 1'b1;
            last_gas  <= now_r;
          end
        end
        S_UPD_BATT: begin
          updates_total <= updates_total + 1'b1;
          if (push_en) begin
            last_battery  <= now_r;
            batt_mv_held  <= bmv_calc;
            batt_pct_held <= bpct_calc;
          end
        end
        S_POP_DATA: begin
          rd_idx <= next_slot(rd_idx);
          held   <= held - 1'b1;
        end
        S_SRCH: begin
          chk_valid <= issue && !match;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          op_r       <= op_t'(operation);
          now_r      <= now_ms;
          pready_r   <= pulse_ready;
          red_r      <= pulse_red;
          ir_r       <= pulse_infrared;
          gas_adc_r  <= gas_adc;
          heater_r   <= heater_active;
          batt_adc_r <= battery_adc;
          want_r     <= wanted_kind;
          mask       <= '0;
          res_found  <= 1'b0;
          res_entry  <= '0;
          scan_slot  <= prev_slot(wr_idx);
          scan_left  <= held;
        end
      end
      S_UPD_PULSE: if (push_en) mask[0] <= 1'b1;
      S_UPD_GAS:   if (push_en) mask[1] <= 1'b1;
      S_BATT_MV:   bmv_calc  <= adc_to_mv(batt_adc_r);
      S_BATT_PCT:  bpct_calc <= pct_val;
      S_UPD_BATT:  if (push_en) mask[2] <= 1'b1;
      S_POP:       ;
      S_POP_DATA: begin
        res_found <= 1'b1;
        res_entry <= rd_q;
      end
      S_SRCH: begin
        if (match) begin
          res_found <= 1'b1;
          res_entry <= rd_q;
        end else if (issue) begin
          scan_slot <= prev_slot(scan_slot);
          scan_left <= scan_left - 1'b1;
        end
      end
      S_FINISH: begin
        found              <= res_found;
        sample_time        <= res_entry.stamp;
        sample_kind        <= res_entry.kind;
        first_value        <= res_entry.first;
        second_value       <= res_entry.second;
        occupancy          <= held;
        pushed_mask        <= (op_r == OP_UPDATE) ? mask : 3'b000;
        pulse_samples      <= pulse_total;
        gas_samples        <= gas_total;
        update_count       <= updates_total;
        battery_millivolts <= batt_mv_held;
        battery_charge     <= batt_pct_held;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/tssc_checker.sv =====
// tssc_checker: port-level assertions for the sample collector, bound to the
// top level; depends on tssc_pkg and timed_sensor_sample_collector
`default_nettype none

module tssc_checker
  import tssc_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic              found,
  input wire logic [TIME_W-1:0] sample_time,
  input wire logic [KIND_W-1:0] sample_kind,
  input wire logic [VAL_W-1:0]  first_value,
  input wire logic [VAL_W-1:0]  second_value,
  input wire logic [CNT_W-1:0]  occupancy
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // a result only appears once the block is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // a missing sample reports zeroed sample fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (sample_time == '0 && sample_kind == '0 &&
                          first_value == '0 && second_value == '0))
    else $error("sample fields not zero without a sample");

  // returned samples carry a real kind
  a_kind_valid: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (sample_kind != KIND_NONE))
    else $error("returned sample has an invalid kind");

  // occupancy never exceeds the buffer depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (occupancy <= CNT_W'(BUFFER_DEPTH)))
    else $error("occupancy beyond buffer depth");

endmodule

bind timed_sensor_sample_collector tssc_checker u_tssc_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .found        (found),
  .sample_time  (sample_time),
  .sample_kind  (sample_kind),
  .first_value  (first_value),
  .second_value (second_value),
  .occupancy    (occupancy)
);

`default_nettype wire
